/* src/mfr_pkg.sv */
package mfr_pkg;

  localparam int unsigned FRAME_LEN = 23;

  localparam logic [7:0] HEADER_BYTE = 8'h55;
  localparam logic [7:0] READ_CMD    = 8'h58;

  localparam logic [15:0] TIMEOUT_RESET = 16'd300;
  localparam logic [1:0]  ADDR_RESET    = 2'd0;

  // The configuration port carries one more index bit than the register list
  // needs, so writes to unknown indexes are visible and ignored.
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_MS     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEVICE_ADDRESS = 2'd1;

  typedef enum logic [1:0] {
    EV_GOOD    = 2'd0,
    EV_CSUM    = 2'd1,
    EV_JUNK    = 2'd2,
    EV_TIMEOUT = 2'd3
  } event_e;

endpackage

/* src/mfr_if.sv */
interface mfr_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] rx_byte;

  modport source (output valid, output action, output rx_byte, input ready);
  modport sink   (input valid, input action, input rx_byte, output ready);
endinterface

interface mfr_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         event_res;
  logic [23:0]        current_rms;
  logic [23:0]        voltage_rms;
  logic [23:0]        fast_current_rms;
  logic signed [23:0] active_power;
  logic [23:0]        energy_count;
  logic [15:0]        line_period;
  logic [7:0]         status_byte;
  logic [31:0]        good_samples;
  logic [31:0]        checksum_fails;
  logic [31:0]        junk_count;
  logic [31:0]        timeout_count;

  modport source (
    output valid, input ready,
    output event_res, output current_rms, output voltage_rms, output fast_current_rms,
    output active_power, output energy_count, output line_period, output status_byte,
    output good_samples, output checksum_fails, output junk_count, output timeout_count
  );
  modport sink (
    input valid, output ready,
    input event_res, input current_rms, input voltage_rms, input fast_current_rms,
    input active_power, input energy_count, input line_period, input status_byte,
    input good_samples, input checksum_fails, input junk_count, input timeout_count
  );
endinterface

/* src/mfr_cell.sv */
module mfr_cell (
  input  logic       clk_i,
  input  logic       shift_i,
  input  logic [7:0] data_i,
  output logic [7:0] data_o
);

  logic [7:0] data_q;
  logic [7:0] data_d;

  assign data_d = shift_i ? data_i : data_q;

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

/* src/mfr_chain.sv */
module mfr_chain #(
  parameter int unsigned Depth = mfr_pkg::FRAME_LEN - 1
) (
  input  logic       clk_i,
  input  logic       shift_i,
  input  logic [7:0] data_i,
  output logic [7:0] bytes_o [Depth]
);

  // New bytes enter at the top and move one cell down per shift, so after a
  // full frame cell k holds frame byte k.
  for (genvar k = 0; k < Depth; k++) begin : g_cell
    logic [7:0] feed;
    if (k == Depth - 1) begin : g_top
      assign feed = data_i;
    end else begin : g_mid
      assign feed = bytes_o[k+1];
    end
    mfr_cell u_cell (
      .clk_i  (clk_i),
      .shift_i(shift_i),
      .data_i (feed),
      .data_o (bytes_o[k])
    );
  end

endmodule

/* src/meter_frame_receiver.sv */
// Receiver for the energy meter's full-packet UART reply. Each request on
// in_i is either a received byte (action 0) or a one millisecond tick
// (action 1); one request is taken every clock cycle, and the result of a
// request that produces one is in the output register on the next cycle.
// Input is held off only while a result waits in out_o and the sink is not
// ready. Bytes outside a frame that are not the 0x55 header give a junk
// event; a frame is 23 bytes from the header, its bytes move down a row of
// byte cells, and the closing checksum byte gives a good sample or a
// checksum error. A frame still open after timeout_ms ticks is dropped with
// a timeout event on the next tick. Every result carries the four wrapping
// event counters after its own update. Configuration writes go straight to
// the registers and belong to idle periods.
module meter_frame_receiver #(
  parameter int unsigned FrameLen = mfr_pkg::FRAME_LEN
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [mfr_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [mfr_pkg::CFG_DATA_W-1:0] cfg_data_i,
  mfr_in_if.sink                         in_i,
  mfr_out_if.source                      out_o
);
  import mfr_pkg::*;

  localparam int unsigned Depth = FrameLen - 1;
  localparam int unsigned IdxW  = $clog2(FrameLen);
  localparam logic [IdxW-1:0] LastData = IdxW'(Depth);

  logic [15:0]     timeout_q;
  logic [1:0]      addr_q;
  logic [IdxW-1:0] idx_q, idx_d;
  logic [7:0]      sum_q, sum_d;
  logic [15:0]     elapsed_q, elapsed_d;
  logic [31:0]     good_q, good_d;
  logic [31:0]     csum_q, csum_d;
  logic [31:0]     junk_q, junk_d;
  logic [31:0]     tmo_q, tmo_d;

  logic            out_valid_q;
  event_e          event_q;
  logic [23:0]     cur_q, volt_q, fast_q, energy_q;
  logic [23:0]     power_q;
  logic [15:0]     period_q;
  logic [7:0]      status_q;

  logic            accept;
  logic            shift;
  logic            emit;
  logic            with_data;
  event_e          event_d;
  logic [7:0]      sum_base;
  logic [7:0]      frame [Depth];

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;

  mfr_chain #(
    .Depth(Depth)
  ) u_chain (
    .clk_i  (clk_i),
    .shift_i(shift),
    .data_i (in_i.rx_byte),
    .bytes_o(frame)
  );

  assign sum_base = (idx_q == '0) ? (READ_CMD | {6'd0, addr_q}) : sum_q;

  always_comb begin
    idx_d     = idx_q;
    sum_d     = sum_q;
    elapsed_d = elapsed_q;
    good_d    = good_q;
    csum_d    = csum_q;
    junk_d    = junk_q;
    tmo_d     = tmo_q;
    shift     = 1'b0;
    emit      = 1'b0;
    with_data = 1'b0;
    event_d   = EV_GOOD;
    if (accept) begin
      if (in_i.action) begin
        if (idx_q != '0) begin
          if (elapsed_q >= timeout_q) begin
            tmo_d     = tmo_q + 32'd1;
            idx_d     = '0;
            elapsed_d = '0;
            sum_d     = '0;
            emit      = 1'b1;
            event_d   = EV_TIMEOUT;
          end else begin
            elapsed_d = elapsed_q + 16'd1;
          end
        end
      end else if (idx_q == '0 && in_i.rx_byte != HEADER_BYTE) begin
        junk_d  = junk_q + 32'd1;
        emit    = 1'b1;
        event_d = EV_JUNK;
      end else if (idx_q < LastData) begin
        // Header or payload byte: store it and extend the running sum.
        shift     = 1'b1;
        sum_d     = sum_base + in_i.rx_byte;
        idx_d     = idx_q + 1'b1;
        elapsed_d = (idx_q == '0) ? 16'd0 : elapsed_q;
      end else begin
        idx_d     = '0;
        elapsed_d = '0;
        sum_d     = '0;
        emit      = 1'b1;
        if (~sum_q == in_i.rx_byte) begin
          good_d    = good_q + 32'd1;
          with_data = 1'b1;
          event_d   = EV_GOOD;
        end else begin
          csum_d  = csum_q + 32'd1;
          event_d = EV_CSUM;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q   <= TIMEOUT_RESET;
      addr_q      <= ADDR_RESET;
      idx_q       <= '0;
      sum_q       <= '0;
      elapsed_q   <= '0;
      good_q      <= '0;
      csum_q      <= '0;
      junk_q      <= '0;
      tmo_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_TIMEOUT_MS:     timeout_q <= cfg_data_i;
          REG_DEVICE_ADDRESS: addr_q    <= cfg_data_i[1:0];
          default: ;
        endcase
      end
      idx_q     <= idx_d;
      sum_q     <= sum_d;
      elapsed_q <= elapsed_d;
      good_q    <= good_d;
      csum_q    <= csum_d;
      junk_q    <= junk_d;
      tmo_q     <= tmo_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload; measurement fields read as zero unless the frame is good.
  always_ff @(posedge clk_i) begin
    if (emit) begin
      event_q  <= event_d;
      cur_q    <= with_data ? {frame[3], frame[2], frame[1]} : 24'd0;
      volt_q   <= with_data ? {frame[6], frame[5], frame[4]} : 24'd0;
      fast_q   <= with_data ? {frame[9], frame[8], frame[7]} : 24'd0;
      power_q  <= with_data ? {frame[12], frame[11], frame[10]} : 24'd0;
      energy_q <= with_data ? {frame[15], frame[14], frame[13]} : 24'd0;
      period_q <= with_data ? {frame[17], frame[16]} : 16'd0;
      status_q <= with_data ? frame[19] : 8'd0;
    end
  end

  logic [31:0] good_o_q, csum_o_q, junk_o_q, tmo_o_q;

  always_ff @(posedge clk_i) begin
    if (emit) begin
      good_o_q <= good_d;
      csum_o_q <= csum_d;
      junk_o_q <= junk_d;
      tmo_o_q  <= tmo_d;
    end
  end

  assign out_o.valid            = out_valid_q;
  assign out_o.event_res        = event_q;
  assign out_o.current_rms      = cur_q;
  assign out_o.voltage_rms      = volt_q;
  assign out_o.fast_current_rms = fast_q;
  assign out_o.active_power     = $signed(power_q);
  assign out_o.energy_count     = energy_q;
  assign out_o.line_period      = period_q;
  assign out_o.status_byte      = status_q;
  assign out_o.good_samples     = good_o_q;
  assign out_o.checksum_fails   = csum_o_q;
  assign out_o.junk_count       = junk_o_q;
  assign out_o.timeout_count    = tmo_o_q;

endmodule

/* src/mfr_checker.sv */
module mfr_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [1:0]  event_res_i,
  input logic [23:0] current_rms_i,
  input logic [7:0]  status_byte_i,
  input logic [31:0] good_samples_i,
  input logic [31:0] junk_count_i
);
  import mfr_pkg::*;

  // With no result pending the receiver must take any request.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input stalled with an empty output register");

  // A new result only follows an accepted request.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_valid_i && in_ready_i))
    else $error("result appeared without an accepted request");

  // Only good samples carry measurement data.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && event_res_i != EV_GOOD |->
      current_rms_i == 24'd0 && status_byte_i == 8'd0)
    else $error("measurement data on a non-sample event");

  // A stalled result holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      out_valid_i && $stable(event_res_i) && $stable(good_samples_i) &&
      $stable(junk_count_i))
    else $error("stalled result changed");

endmodule

bind meter_frame_receiver mfr_checker u_mfr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .event_res_i   (out_o.event_res),
  .current_rms_i (out_o.current_rms),
  .status_byte_i (out_o.status_byte),
  .good_samples_i(out_o.good_samples),
  .junk_count_i  (out_o.junk_count)
);
